FILE: src/mhpq_pkg.sv
// Shared types and constants of the max-heap priority queue.
package mhpq_pkg;

  localparam int KEY_W    = 32;
  localparam int COUNT_W  = 7;
  localparam int STATUS_W = 2;

  typedef logic signed [KEY_W-1:0] key_t;
  typedef logic [STATUS_W-1:0]     status_t;

  localparam logic    OP_INSERT = 1'b0;
  localparam logic    OP_DELETE = 1'b1;

  localparam status_t STATUS_OK    = 2'd0;
  localparam status_t STATUS_FULL  = 2'd1;
  localparam status_t STATUS_EMPTY = 2'd2;

endpackage

FILE: src/max_heap_priority_queue.sv
// Binary max-heap priority queue built around a synchronous key memory.
//
// The block keeps up to CAPACITY signed 32-bit keys in a binary max-heap. Each input
// transaction either inserts in_value (in_op = 0) or deletes the maximum (in_op = 1), and
// each one produces exactly one output transaction carrying the removed maximum (zero
// unless a delete succeeded), the root key after the operation (zero when empty), the
// key count and a status. An insert into a full heap or a delete from an empty heap
// changes nothing and is reported as refused. One transaction is worked on at a time.
// The sift loop handles one heap level at a time, in a memory read state followed by a
// compare-and-write state, since the key memory's read ports are registered. The finished
// result moves into an output register once that register is free, so the next transaction
// can be accepted while that result still waits to be taken.
module max_heap_priority_queue
  import mhpq_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_op,
  input  logic signed [31:0]  in_value,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  out_removed_value,
  output logic signed [31:0]  out_top_value,
  output logic [COUNT_W-1:0]  out_entry_count,
  output logic [STATUS_W-1:0] out_status
);

  // Address, count and child-index widths.
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = AW + 2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_DN_LOAD,
    S_DN_RD,
    S_DN_CMP,
    S_PUT,
    S_DONE
  } state_t;

  state_t          state_r;
  logic [CW-1:0]   count_r;
  logic [AW-1:0]   pos_r;
  key_t            key_r;
  key_t            top_r;
  key_t            removed_r;
  status_t         status_r;

  logic            out_valid_r;
  key_t            out_removed_r;
  key_t            out_top_r;
  logic [COUNT_W-1:0] out_count_r;
  status_t         out_status_r;

  // Key memory: one write port and two registered read ports.
  key_t            heap_mem [CAPACITY];
  key_t            rd_a_q;
  key_t            rd_b_q;
  logic [AW-1:0]   rd_addr_a;
  logic [AW-1:0]   rd_addr_b;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  key_t            wr_data;

  // Child and parent positions of the current hole.
  logic [IW-1:0]   left_w;
  logic [IW-1:0]   right_w;
  logic [IW-1:0]   count_w;
  logic [AW-1:0]   parent;
  logic            use_right;
  key_t            pick_val;
  logic [AW-1:0]   pick_idx;
  logic            full;
  logic            out_free;

  assign left_w  = {1'b0, pos_r, 1'b1};
  assign right_w = left_w + IW'(1);
  assign count_w = IW'(count_r);
  assign parent  = (pos_r - AW'(1)) >> 1;
  assign full    = (count_r == CW'(CAPACITY));
  assign out_free = !out_valid_r || out_ready;

  // Ties between the two children go to the left one.
  assign use_right = (right_w < count_w) && (rd_b_q > rd_a_q);
  assign pick_val  = use_right ? rd_b_q : rd_a_q;
  assign pick_idx  = use_right ? right_w[AW-1:0] : left_w[AW-1:0];

  always_comb begin
    // While idle, port A fetches the last key so a delete can start at once.
    case (state_r)
      S_IDLE:  rd_addr_a = AW'(count_r - CW'(1));
      S_UP_RD: rd_addr_a = parent;
      default: rd_addr_a = left_w[AW-1:0];
    endcase
    rd_addr_b = right_w[AW-1:0];

    wr_en   = 1'b0;
    wr_addr = pos_r;
    wr_data = key_r;
    case (state_r)
      S_UP_CMP: begin
        // The smaller parent moves down into the hole.
        if (key_r > rd_a_q) begin
          wr_en   = 1'b1;
          wr_data = rd_a_q;
        end
      end
      S_DN_CMP: begin
        // The larger child moves up into the hole.
        if (pick_val > key_r) begin
          wr_en   = 1'b1;
          wr_data = pick_val;
        end
      end
      S_PUT: begin
        wr_en = 1'b1;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      heap_mem[wr_addr] <= wr_data;
    end
    rd_a_q <= heap_mem[rd_addr_a];
    rd_b_q <= heap_mem[rd_addr_b];
  end

  assign in_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end

      // The root key is mirrored in a register so it never needs a read.
      if (wr_en && (wr_addr == '0)) begin
        top_r <= wr_data;
      end

      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            removed_r <= '0;
            status_r  <= STATUS_OK;
            if (in_op == OP_INSERT) begin
              if (full) begin
                status_r <= STATUS_FULL;
                state_r  <= S_DONE;
              end else begin
                key_r   <= in_value;
                pos_r   <= count_r[AW-1:0];
                count_r <= count_r + CW'(1);
                state_r <= (count_r == '0) ? S_PUT : S_UP_RD;
              end
            end else begin
              if (count_r == '0) begin
                status_r <= STATUS_EMPTY;
                state_r  <= S_DONE;
              end else begin
                removed_r <= top_r;
                count_r   <= count_r - CW'(1);
                pos_r     <= '0;
                state_r   <= (count_r == CW'(1)) ? S_DONE : S_DN_LOAD;
              end
            end
          end
        end
        S_UP_RD: begin
          state_r <= S_UP_CMP;
        end
        S_UP_CMP: begin
          if (key_r > rd_a_q) begin
            pos_r   <= parent;
            state_r <= (parent == '0) ? S_PUT : S_UP_RD;
          end else begin
            state_r <= S_PUT;
          end
        end
        S_DN_LOAD: begin
          // The last key, read while idle, becomes the key that sinks from the root.
          key_r   <= rd_a_q;
          state_r <= (left_w >= count_w) ? S_PUT : S_DN_CMP;
        end
        S_DN_RD: begin
          state_r <= (left_w >= count_w) ? S_PUT : S_DN_CMP;
        end
        S_DN_CMP: begin
          if (pick_val > key_r) begin
            pos_r   <= pick_idx;
            state_r <= S_DN_RD;
          end else begin
            state_r <= S_PUT;
          end
        end
        S_PUT: begin
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r   <= 1'b1;
            out_removed_r <= removed_r;
            out_top_r     <= (count_r != '0) ? top_r : '0;
            out_count_r   <= COUNT_W'(count_r);
            out_status_r  <= status_r;
            state_r       <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_removed_value = out_removed_r;
  assign out_top_value     = out_top_r;
  assign out_entry_count   = out_count_r;
  assign out_status        = out_status_r;

  // The key count never exceeds the capacity of the memory.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("key count exceeds capacity");

  // The memory is written only during a sift, never while idle or reporting.
  a_write_in_sift: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> !(state_r == S_IDLE || state_r == S_DONE))
    else $error("key memory written outside a sift");

  // A refused insert leaves the key count unchanged.
  a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_op == OP_INSERT) && full) |=> (count_r == $past(count_r)))
    else $error("refused insert changed the key count");

  // A refused delete reports from an empty heap.
  a_empty_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_op == OP_DELETE) && (count_r == '0))
      |=> (count_r == '0) && (status_r == STATUS_EMPTY))
    else $error("refused delete changed the heap");

endmodule

FILE: tb/max_heap_priority_queue_test.sv
// Self-checking testbench for the max-heap priority queue with a built-in heap predictor.
module max_heap_priority_queue_test;
  import mhpq_pkg::*;

  // Same capacity as the block's default. The predictor uses it to decide
  // when an insert must be refused.
  localparam int CAPACITY = 64;

  // An insert sifts up through at most log2(64) = 6 levels, and a delete sifts
  // down through fewer. The tail wait after the last result allows a comfortable
  // margin over the longest operation.
  localparam int TAIL_CYCLES = 40;

  // The long receiver hold-off used to fill the block and stall its input.
  localparam int HOLD_CYCLES = 400;

  // About 1150 items, each delayed at worst by a long sender gap, the sift and
  // a long receiver stall, fit well within the limit.
  localparam int CYCLE_LIMIT = 600000;

  localparam key_t KEY_MAX = 32'sh7FFF_FFFF;
  localparam key_t KEY_MIN = 32'sh8000_0000;

  // Number of mismatch lines printed. The count itself covers every mismatch.
  localparam int MAX_PRINTED = 100;

  // One result as the block reports it.
  typedef struct {
    key_t                removed;
    key_t                top;
    logic [COUNT_W-1:0]  count;
    status_t             status;
  } heap_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               in_op = OP_INSERT;
  logic signed [31:0] in_value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] out_removed_value;
  logic signed [31:0] out_top_value;
  logic [COUNT_W-1:0] out_entry_count;
  logic [STATUS_W-1:0] out_status;

  // The predictor's own copy of the heap. It is written in the same order as
  // the block's store, so the tie rules must match exactly.
  key_t heap_keys[CAPACITY];
  int   heap_size = 0;

  // Results predicted for accepted transactions, oldest first.
  heap_result_t pending_results[$];

  // Idle and stall rates for the current phase, in percent.
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;

  // The test raises hold_request. The hold process then keeps out_ready low
  // for the long hold-off and clears the request when it is done.
  logic hold_request = 1'b0;
  logic receiver_held = 1'b0;

  int error_count = 0;
  int cycle_count = 0;
  int inserts_sent = 0;
  int deletes_sent = 0;
  int results_checked = 0;
  int refused_full_seen = 0;
  int refused_empty_seen = 0;

  max_heap_priority_queue #(
    .CAPACITY(CAPACITY)
  ) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_removed_value(out_removed_value),
    .out_top_value    (out_top_value),
    .out_entry_count  (out_entry_count),
    .out_status       (out_status)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // The watchdog. If the run has not finished by the cycle limit, something
  // hung, either a handshake or a result that never came.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles with %0d results outstanding",
             cycle_count, pending_results.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Applies one operation to the predicted heap and returns the result it
  // should produce. An insert appends the key and sifts it up while the parent
  // is strictly smaller. A delete moves the last key to the root and sifts it
  // down toward the larger child, and the left child wins a tie. A refused
  // operation leaves the heap as it is.
  function automatic heap_result_t apply_heap_op(logic op, key_t value);
    heap_result_t res;
    int           pos;
    int           parent;
    int           left;
    int           right;
    int           pick;
    key_t         swap_key;
    bit           done;
    res.removed = '0;
    res.status  = STATUS_OK;
    done = 1'b0;
    if (op == OP_INSERT) begin
      if (heap_size >= CAPACITY) begin
        res.status = STATUS_FULL;
      end else begin
        heap_keys[heap_size] = value;
        pos = heap_size;
        heap_size++;
        while (pos != 0 && !done) begin
          parent = (pos - 1) / 2;
          if (heap_keys[pos] > heap_keys[parent]) begin
            swap_key          = heap_keys[pos];
            heap_keys[pos]    = heap_keys[parent];
            heap_keys[parent] = swap_key;
            pos = parent;
          end else begin
            done = 1'b1;
          end
        end
      end
    end else begin
      if (heap_size == 0) begin
        res.status = STATUS_EMPTY;
      end else begin
        res.removed = heap_keys[0];
        heap_size--;
        heap_keys[0] = heap_keys[heap_size];
        pos = 0;
        while (!done) begin
          left  = 2 * pos + 1;
          right = left + 1;
          if (left >= heap_size) begin
            done = 1'b1;
          end else begin
            pick = left;
            if (right < heap_size && heap_keys[right] > heap_keys[left]) pick = right;
            if (heap_keys[pick] > heap_keys[pos]) begin
              swap_key        = heap_keys[pos];
              heap_keys[pos]  = heap_keys[pick];
              heap_keys[pick] = swap_key;
              pos = pick;
            end else begin
              done = 1'b1;
            end
          end
        end
      end
    end
    res.top   = (heap_size != 0) ? heap_keys[0] : key_t'(0);
    res.count = heap_size[COUNT_W-1:0];
    return res;
  endfunction

  // Prints one mismatch line and counts it. Past MAX_PRINTED lines it only
  // counts, so a badly broken block does not flood the log.
  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    if (error_count < MAX_PRINTED)
      $display("Mismatch at cycle %0d: %s expected %0h got %0h", cycle_count, what, want, got);
    error_count++;
  endtask

  // Offers one transaction and returns at the edge where it is accepted.
  // Inputs change only at the falling edge. in_valid is left high after
  // acceptance: the next call either puts a new payload on it or lowers it to
  // idle, so in_valid never gets two updates in one time step.
  task automatic send_heap_op(logic op, key_t value);
    heap_result_t res;
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_op    <= op;
    in_value <= value;
    // in_ready is read right after the edge, before any register updates at
    // that edge take effect. It therefore holds the value the block saw.
    do @(posedge clk); while (!in_ready);
    res = apply_heap_op(op, value);
    pending_results.insert(pending_results.size(), res);
    if (op == OP_INSERT) inserts_sent++;
    else deletes_sent++;
  endtask

  // Lowers in_valid after a test's last transaction. Without this the block
  // would accept the last payload a second time while the test waits.
  task automatic stop_sending;
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_for_drain;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Picks a key from one of three pools: any 32-bit pattern, a narrow band
  // around zero that yields many equal keys, or the extremes.
  function automatic key_t pick_key(int pool);
    case (pool)
      0: return key_t'($urandom);
      1: return key_t'(int'($urandom_range(16)) - 8);
      default: begin
        case ($urandom_range(3))
          0: return KEY_MAX;
          1: return KEY_MIN;
          2: return key_t'(0);
          default: return key_t'(-1);
        endcase
      end
    endcase
  endfunction

  // Receiver side. out_ready changes at the falling edge. It is low for the
  // whole of a hold-off and otherwise follows the stall rate of the phase.
  always @(negedge clk) begin
    if (receiver_held) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // The long hold-off, counted in its own process. It starts at the next
  // rising edge after the request, so it never races the ready driver.
  initial begin : receiver_hold
    forever begin
      wait (hold_request);
      @(posedge clk);
      receiver_held = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      receiver_held = 1'b0;
      hold_request = 1'b0;
    end
  end

  // Result checker. Every transaction on the result channel is matched field
  // by field against the oldest prediction.
  always @(posedge clk) begin : result_check
    heap_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, top value", '0, out_top_value);
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (want.status == STATUS_FULL) refused_full_seen++;
        if (want.status == STATUS_EMPTY) refused_empty_seen++;
        if (out_removed_value !== want.removed)
          report_mismatch("removed value", want.removed, out_removed_value);
        if (out_top_value !== want.top)
          report_mismatch("top value", want.top, out_top_value);
        if (out_entry_count !== want.count)
          report_mismatch("entry count", 32'(want.count), 32'(out_entry_count));
        if (out_status !== want.status)
          report_mismatch("status", 32'(want.status), 32'(out_status));
      end
    end
  end

  // Edge cases with a free-running receiver: a delete on an empty heap, the
  // most positive and most negative keys, zero and minus one, equal keys
  // (ties at the parent and between children), and a drain down through the
  // delete of the last key to a second empty delete. The value on a delete is
  // meant to be ignored, so it carries a random pattern or, on the last delete, KEY_MAX.
  task automatic test_directed_cases;
    key_t directed_keys[9];
    directed_keys = '{key_t'(0), KEY_MAX, KEY_MIN, key_t'(-1), key_t'(1), KEY_MAX,
                      key_t'(5), key_t'(5), key_t'(5)};
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    send_heap_op(OP_DELETE, key_t'($urandom));
    foreach (directed_keys[i]) send_heap_op(OP_INSERT, directed_keys[i]);
    repeat (9) send_heap_op(OP_DELETE, key_t'($urandom));
    send_heap_op(OP_DELETE, KEY_MAX);
    stop_sending();
    wait_for_drain();
  endtask

  // Fills the heap to capacity and tries two inserts that must be refused,
  // one of them with the largest key, which must not reach the top. Then it
  // drains everything and ends with a delete on the empty heap.
  task automatic test_full_heap;
    sender_idle_pct    = 10;
    receiver_stall_pct = 10;
    repeat (CAPACITY) send_heap_op(OP_INSERT, pick_key($urandom_range(1)));
    send_heap_op(OP_INSERT, KEY_MAX);
    send_heap_op(OP_INSERT, key_t'($urandom));
    repeat (CAPACITY + 1) send_heap_op(OP_DELETE, key_t'($urandom));
    stop_sending();
    wait_for_drain();
  endtask

  // Random traffic in bursts. Each burst leans toward inserts, toward deletes
  // or toward neither, so the fill level wanders between empty and full. The
  // refused operations at those two ends are the noise among otherwise
  // well-formed traffic.
  task automatic test_random_traffic(int item_total, int idle_pct, int stall_pct);
    int sent;
    int burst_len;
    int insert_pct;
    int pool;
    sent = 0;
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    while (sent < item_total) begin
      burst_len = $urandom_range(60, 20);
      case ($urandom_range(2))
        0: insert_pct = 80;
        1: insert_pct = 50;
        default: insert_pct = 20;
      endcase
      pool = $urandom_range(2);
      repeat (burst_len) begin
        if ($urandom_range(99) < insert_pct) send_heap_op(OP_INSERT, pick_key(pool));
        else send_heap_op(OP_DELETE, key_t'($urandom));
        sent++;
      end
    end
    stop_sending();
    wait_for_drain();
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering
  // back-to-back transactions. The block can hold only a finished result and
  // one more operation, so in_ready must drop until the hold-off ends. After
  // that every result must still come out in order.
  task automatic test_output_backpressure;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    hold_request = 1'b1;
    repeat (8) send_heap_op(OP_INSERT, pick_key($urandom_range(2)));
    repeat (4) send_heap_op(OP_DELETE, key_t'($urandom));
    stop_sending();
    wait (!hold_request);
    wait_for_drain();
  endtask

  initial begin : run_tests
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    test_full_heap();
    test_random_traffic(240, 0, 0);
    test_random_traffic(240, 72, 0);
    test_random_traffic(240, 0, 72);
    test_random_traffic(240, 17, 17);
    test_output_backpressure();

    // Let the block settle. Any result that shows up now has no prediction
    // waiting and is reported by the checker.
    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d inserts and %0d deletes, checked %0d results in %0d cycles",
             inserts_sent, deletes_sent, results_checked, cycle_count);
    $display("Refused inserts into a full heap: %0d, refused deletes from an empty heap: %0d",
             refused_full_seen, refused_empty_seen);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches found", error_count);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
